>>> hw/rtl/tcgp_pkg.sv
package tcgp_pkg;

  // Layout constants
  localparam int unsigned COLUMN_COUNT = 3;
  localparam int unsigned COLUMN_GAP   = 12;
  localparam int unsigned CELL_WIDTH   = 7;
  localparam int unsigned LINE_HEIGHT  = 10;
  localparam int unsigned MAX_LINES    = 64;
  localparam int unsigned MAX_CELLS    = 160;
  localparam int unsigned GLYPH_ROWS   = 7;

  localparam int unsigned PIX_W      = 13;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X         = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y         = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_WIDTH     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHARS_PER_LINE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINES_PER_COLUMN = 3'd4;

  // Special text bytes
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  // One 5x7 glyph, row 0 on top
  typedef logic [0:6][4:0] glyph_t;

  function automatic glyph_t glyph_of(input logic [7:0] c);
    logic [7:0] up;
    glyph_t     g;
    up = (c inside {[8'h61:8'h7A]}) ? (c - 8'h20) : c;
    case (up)
      8'h41: g = '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
      8'h42: g = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      8'h43: g = '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      8'h44: g = '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h45: g = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      8'h46: g = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h47: g = '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      8'h48: g = '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8'h49: g = '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h4A: g = '{5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      8'h4B: g = '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4C: g = '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      8'h4D: g = '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4E: g = '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4F: g = '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h50: g = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h51: g = '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      8'h52: g = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      8'h53: g = '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h54: g = '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: g = '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h56: g = '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      8'h57: g = '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      8'h58: g = '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      8'h59: g = '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5A: g = '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}; // Z
      8'h30: g = '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
      8'h31: g = '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h32: g = '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h33: g = '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      8'h34: g = '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      8'h35: g = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      8'h36: g = '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37: g = '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: g = '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39: g = '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}; // 9
      8'h3A: g = '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // colon
      8'h2D: g = '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // dash
      8'h2F: g = '{5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10}; // slash
      8'h2E: g = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}; // dot
      default: g = '{5'h1E, 5'h11, 5'h01, 5'h06, 5'h04, 5'h00, 5'h04}; // unknown
    endcase
    return g;
  endfunction

endpackage

>>> hw/rtl/text_console_glyph_placer_unit.sv
// Text console glyph placer.
// Input stream (in_*): one text byte per transfer, in_tdata[7:0] = char_code,
// in_tlast = end_of_text. Carriage return is dropped, line feed and a full line
// advance the cursor, other bytes are drawn from a 5x7 font at the pen position.
// Result stream (out_*): out_tuser = kind (glyph row, clear region, flush),
// out_tdata = {pad, row_bits, pixel_y, pixel_x}, out_tlast marks the final
// result caused by one input byte.
// Cursor and pen update in the cycle a byte is taken; the byte's results are
// then queued in a job register and shifted out one per cycle while out_tready
// is high, through an output register. Each result passes the job register
// and then the output register. A byte has up to 9 results (clear, seven
// rows, flush); the job register frees in the cycle its last result moves
// out, so a new byte is taken then. A byte with no result leaves no job.
// When out_tready is low the output register holds its result and the job
// register holds the rest; in_tready drops once the job is still pending.
// Reset (rst_n low, synchronous) empties both registers, homes the cursor to
// the first line of the first column and loads the register defaults.
// Configuration writes (cfg_we) are registered and are meant for idle time.
module text_console_glyph_placer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [tcgp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tcgp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // text input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] char_code
  input  logic                                in_tlast,   // end_of_text
  // results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // [12:0] pixel_x,
                                                          // [25:13] pixel_y,
                                                          // [30:26] row_bits
  output logic [1:0]                          out_tuser,  // [1:0] kind
  output logic                                out_tlast   // last
);
  import tcgp_pkg::*;

  // Configuration registers
  logic [11:0] origin_x_r, origin_y_r, column_width_r;
  logic [7:0]  chars_per_line_r;
  logic [6:0]  lines_per_column_r;

  // Cursor and pen
  logic [1:0]       text_column_r, text_column_nxt;
  logic [5:0]       cursor_line_r, cursor_line_nxt;
  logic [7:0]       cursor_cell_r, cursor_cell_nxt;
  logic [PIX_W-1:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;

  // Pending job: results still to emit for the current byte
  logic             job_clear_r, job_clear_nxt;
  logic             job_rows_r, job_rows_nxt;
  logic             job_flush_r, job_flush_nxt;
  logic [2:0]       job_row_r, job_row_nxt;
  logic [7:0]       job_code_r;
  logic [PIX_W-1:0] job_x_r, job_y_r;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, cur_kind;
  logic [PIX_W-1:0] out_x_r, out_y_r, cur_x, cur_y;
  logic [4:0]       out_bits_r, cur_bits;
  logic             out_last_r, cur_last;

  // Cursor logic
  logic             in_accept;
  logic             is_lf, is_cr, is_space, draw, do_nl;
  logic [6:0]       lines_eff;
  logic [7:0]       cells_eff;
  logic             line_full, col_wrap, clear_hit;
  logic [2:0]       col_inc;
  logic [1:0]       new_col;
  logic [5:0]       new_line;
  logic [12:0]      col_step;
  logic [14:0]      col_off;
  logic [15:0]      left_sum, top_sum;
  logic [PIX_W-1:0] base_x, base_y;
  logic [7:0]       base_cell;

  // Emitter
  logic   job_any, advance;
  glyph_t cur_glyph;

  assign in_accept = in_tvalid && in_tready;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r         <= 12'd8;
      origin_y_r         <= 12'd16;
      column_width_r     <= 12'd328;
      chars_per_line_r   <= 8'd45;
      lines_per_column_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ORIGIN_X:         origin_x_r         <= cfg_wdata;
        CFG_ORIGIN_Y:         origin_y_r         <= cfg_wdata;
        CFG_COLUMN_WIDTH:     column_width_r     <= cfg_wdata;
        CFG_CHARS_PER_LINE:   chars_per_line_r   <= cfg_wdata[7:0];
        CFG_LINES_PER_COLUMN: lines_per_column_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Cursor step for the byte at the input
  always_comb begin
    is_lf    = (in_tdata == CHAR_LF);
    is_cr    = (in_tdata == CHAR_CR);
    is_space = (in_tdata == CHAR_SPACE);
    draw     = !is_lf && !is_cr;

    // clamp limits; zero compares as always-full
    lines_eff = (lines_per_column_r > 7'(MAX_LINES)) ? 7'(MAX_LINES) : lines_per_column_r;
    cells_eff = (chars_per_line_r > 8'(MAX_CELLS)) ? 8'(MAX_CELLS) : chars_per_line_r;

    line_full = ({1'b0, cursor_cell_r} + 9'd1) >= {1'b0, cells_eff};
    do_nl     = is_lf || (draw && line_full);

    col_wrap  = ({1'b0, cursor_line_r} + 7'd1) >= lines_eff;
    col_inc   = {1'b0, text_column_r} + 3'd1;
    clear_hit = col_wrap && (col_inc >= 3'(COLUMN_COUNT));
    new_col   = clear_hit ? 2'd0 : (col_wrap ? col_inc[1:0] : text_column_r);
    new_line  = col_wrap ? 6'd0 : (cursor_line_r + 6'd1);

    // column left edge and line top, both wrapping at 13 bits
    col_step = {1'b0, column_width_r} + 13'(COLUMN_GAP);
    col_off  = 15'(new_col) * 15'(col_step);
    left_sum = 16'(origin_x_r) + 16'(col_off);
    top_sum  = 16'(origin_y_r) + 16'(new_line) * 16'(LINE_HEIGHT);

    base_x    = do_nl ? left_sum[PIX_W-1:0] : pen_x_r;
    base_y    = do_nl ? top_sum[PIX_W-1:0]  : pen_y_r;
    base_cell = do_nl ? 8'd0 : cursor_cell_r;

    text_column_nxt = do_nl ? new_col  : text_column_r;
    cursor_line_nxt = do_nl ? new_line : cursor_line_r;
    cursor_cell_nxt = draw ? (base_cell + 8'd1) : base_cell;
    pen_x_nxt       = draw ? (base_x + PIX_W'(CELL_WIDTH)) : base_x;
    pen_y_nxt       = base_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_column_r <= '0;
      cursor_line_r <= '0;
      cursor_cell_r <= '0;
      pen_x_r       <= PIX_W'(8);
      pen_y_r       <= PIX_W'(16);
    end else if (in_accept) begin
      text_column_r <= text_column_nxt;
      cursor_line_r <= cursor_line_nxt;
      cursor_cell_r <= cursor_cell_nxt;
      pen_x_r       <= pen_x_nxt;
      pen_y_r       <= pen_y_nxt;
    end
  end

  // Emitter: pick the next pending result of the job, in clear, rows, flush order
  assign job_any   = job_clear_r || job_rows_r || job_flush_r;
  assign advance   = job_any && (!out_valid_r || out_tready);
  assign cur_glyph = glyph_of(job_code_r);

  always_comb begin
    if (job_clear_r) begin
      cur_kind = KIND_CLEAR;
      cur_x    = '0;
      cur_y    = PIX_W'(origin_y_r);
      cur_bits = '0;
      cur_last = !job_rows_r && !job_flush_r;
    end else if (job_rows_r) begin
      cur_kind = KIND_GLYPH;
      cur_x    = job_x_r;
      cur_y    = job_y_r + PIX_W'(job_row_r);
      cur_bits = cur_glyph[job_row_r];
      cur_last = (job_row_r == 3'(GLYPH_ROWS - 1)) && !job_flush_r;
    end else begin
      cur_kind = KIND_FLUSH;
      cur_x    = '0;
      cur_y    = '0;
      cur_bits = '0;
      cur_last = 1'b1;
    end
  end

  // Take a new byte when no job is pending or the last result leaves now
  assign in_tready = !job_any || (advance && cur_last);

  always_comb begin
    job_clear_nxt = job_clear_r;
    job_rows_nxt  = job_rows_r;
    job_flush_nxt = job_flush_r;
    job_row_nxt   = job_row_r;
    if (in_accept) begin
      job_clear_nxt = do_nl && clear_hit;
      job_rows_nxt  = draw && !is_space;
      job_flush_nxt = in_tlast;
      job_row_nxt   = '0;
    end else if (advance) begin
      if (job_clear_r) begin
        job_clear_nxt = 1'b0;
      end else if (job_rows_r) begin
        job_row_nxt  = job_row_r + 3'd1;
        job_rows_nxt = (job_row_r != 3'(GLYPH_ROWS - 1));
      end else begin
        job_flush_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_clear_r <= 1'b0;
      job_rows_r  <= 1'b0;
      job_flush_r <= 1'b0;
      job_row_r   <= '0;
    end else begin
      job_clear_r <= job_clear_nxt;
      job_rows_r  <= job_rows_nxt;
      job_flush_r <= job_flush_nxt;
      job_row_r   <= job_row_nxt;
    end
  end

  // Job payload: pen position after any line break, and the byte itself
  always_ff @(posedge clk) begin
    if (in_accept) begin
      job_code_r <= in_tdata;
      job_x_r    <= base_x;
      job_y_r    <= base_y;
    end
  end

  // Output register: load on advance, drop once the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r <= cur_kind;
      out_x_r    <= cur_x;
      out_y_r    <= cur_y;
      out_bits_r <= cur_bits;
      out_last_r <= cur_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_bits_r, out_y_r, out_x_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/tcgp_checker.sv
module tcgp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import tcgp_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Flush closes the byte's results and carries no coordinates
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FLUSH) |-> out_tlast && (out_tdata == 32'd0))
    else $error("flush not last or not empty");

  // Clear carries no x and no pattern
  a_clear_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_CLEAR) |->
      (out_tdata[12:0] == 13'd0) && (out_tdata[30:26] == 5'd0))
    else $error("clear result with x or pattern");

endmodule

bind text_console_glyph_placer_unit tcgp_checker u_tcgp_checker (.*);
